// File: src/aes_pkg.sv
// Shared AES constants, S-box tables and GF(2^8) helper functions.
package aes_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_DECRYPT    = 3'd1;
    localparam logic [2:0] CFG_KEY_0      = 3'd2;
    localparam logic [2:0] CFG_KEY_1      = 3'd3;
    localparam logic [2:0] CFG_KEY_2      = 3'd4;
    localparam logic [2:0] CFG_KEY_3      = 3'd5;

    // Key length codes.
    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;

    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1b;

    typedef logic [127:0] block_t;
    typedef logic [31:0]  word_t;

    localparam logic [0:255][7:0] SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [0:255][7:0] INV_SBOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic word_t sub_word(input word_t w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Forward MixColumns of one column, row 0 in the top byte.
    function automatic word_t mix_col(input word_t col);
        logic [7:0] a [4];
        logic [7:0] d [4];
        for (int r = 0; r < 4; r++)
        begin
            a[r] = col[31 - 8 * r -: 8];
        end
        for (int r = 0; r < 4; r++)
        begin
            d[r] = xtime(a[r]) ^ xtime(a[(r + 1) & 3]) ^ a[(r + 1) & 3]
                   ^ a[(r + 2) & 3] ^ a[(r + 3) & 3];
        end
        return {d[0], d[1], d[2], d[3]};
    endfunction

    // Inverse MixColumns of one column with factors 0e, 0b, 0d, 09.
    function automatic word_t inv_mix_col(input word_t col);
        logic [7:0] a  [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] d  [4];
        for (int r = 0; r < 4; r++)
        begin
            a[r]  = col[31 - 8 * r -: 8];
            x2[r] = xtime(a[r]);
            x4[r] = xtime(x2[r]);
            x8[r] = xtime(x4[r]);
        end
        for (int r = 0; r < 4; r++)
        begin
            d[r] = (x8[r] ^ x4[r] ^ x2[r])
                 ^ (x8[(r + 1) & 3] ^ x2[(r + 1) & 3] ^ a[(r + 1) & 3])
                 ^ (x8[(r + 2) & 3] ^ x4[(r + 2) & 3] ^ a[(r + 2) & 3])
                 ^ (x8[(r + 3) & 3] ^ a[(r + 3) & 3]);
        end
        return {d[0], d[1], d[2], d[3]};
    endfunction

endpackage

// File: src/aes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/aes_block_cipher.sv
// AES-128/192/256 block cipher with on-chip key expansion and a shared round unit.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  input    | in_valid / in_stall    | block_upper, block_lower
//  output   | out_valid / out_stall  | result_upper, result_lower
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// After acceptance a block passes the fetch and key-addition states, then Nr
// rounds; the single round unit does one round per cycle while not held, fed
// from the round-key RAM read port. After a key change the first block first
// expands the key, one word per cycle, into 4 * (Nr + 1) words (44, 52 or 60).
// Reset clears control state and the configuration; round keys are rebuilt
// on first use. A stalled finished result is held in the output register
// while the next block is taken; only the last round waits on it.
module aes_block_cipher #(
    parameter int ROUND_KEY_WORDS = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_upper,
    input  logic [63:0] block_lower,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_upper,
    output logic [63:0] result_lower
);

    localparam int ROWS = ROUND_KEY_WORDS / 4;
    localparam int RW   = $clog2(ROWS);
    localparam int WW   = $clog2(ROUND_KEY_WORDS);
    localparam logic [3:0] MAX_NK = (ROUND_KEY_WORDS >= 60) ? 4'd8 :
                                    (ROUND_KEY_WORDS >= 52) ? 4'd6 : 4'd4;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXPAND = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_INIT   = 3'd3;
    localparam logic [2:0] S_ROUND  = 3'd4;

    logic [2:0]          fsm_reg, fsm_next;
    logic [1:0]          key_len_reg;
    logic                dec_reg;
    logic [63:0]         key_reg [4];
    logic                keys_ready_reg, keys_ready_next;
    logic [3:0]          nk_reg, nk_next;
    logic [3:0]          nr_reg, nr_next;
    logic [3:0]          rnd_reg, rnd_next;
    logic [WW-1:0]       widx_reg, widx_next;
    logic [2:0]          kpos_reg, kpos_next;
    logic [7:0]          rcon_reg, rcon_next;
    aes_pkg::word_t      win_reg [8];
    logic [95:0]         rowbuf_reg;
    aes_pkg::block_t     blk_reg, blk_next;
    aes_pkg::block_t     result_reg;
    logic                out_valid_reg, out_valid_next;

    logic                in_take;
    logic                cfg_take;
    logic [3:0]          nk_req;
    aes_pkg::word_t      new_word;
    aes_pkg::word_t      key_word;
    aes_pkg::word_t      t_word;
    aes_pkg::word_t      sw_out;
    logic                is_rot;
    logic                is_sub;
    logic                last_word;
    logic                last_round;
    logic                advance;
    aes_pkg::block_t     round_out;
    logic                ram_we;
    logic                ram_re;
    logic [RW-1:0]       ram_waddr;
    logic [RW-1:0]       ram_raddr;
    logic [3:0]          fetch_step;
    logic [3:0]          fetch_key;
    aes_pkg::block_t     ram_rdata;

    assign cfg_ready    = (fsm_reg == S_IDLE);
    assign in_stall     = (fsm_reg != S_IDLE);
    assign in_take      = in_valid && !in_stall;
    assign cfg_take     = cfg_valid && cfg_ready;
    assign out_valid    = out_valid_reg;
    assign result_upper = result_reg[127:64];
    assign result_lower = result_reg[63:0];

    // Words per key for the configured length, trimmed to what the store holds.
    always_comb
    begin
        case (key_len_reg)
            aes_pkg::KEY_128: nk_req = 4'd4;
            aes_pkg::KEY_192: nk_req = 4'd6;
            default:          nk_req = 4'd8;
        endcase
        if (nk_req > MAX_NK)
        begin
            nk_req = MAX_NK;
        end
    end

    // Key schedule word generator: one word a cycle from a sliding window.
    always_comb
    begin
        key_word = widx_reg[0] ? key_reg[widx_reg[2:1]][31:0]
                               : key_reg[widx_reg[2:1]][63:32];
        t_word    = win_reg[7];
        is_rot    = (widx_reg >= WW'(nk_reg)) && (kpos_reg == 3'd0);
        is_sub    = (nk_reg == 4'd8) && (kpos_reg == 3'd4);
        sw_out    = aes_pkg::sub_word(is_rot ? {t_word[23:0], t_word[31:24]} : t_word);
        if (is_rot)
        begin
            t_word = sw_out ^ {rcon_reg, 24'h0};
        end
        else if (is_sub)
        begin
            t_word = sw_out;
        end
        if (widx_reg < WW'(nk_reg))
        begin
            new_word = key_word;
        end
        else
        begin
            new_word = win_reg[3'(4'd8 - nk_reg)] ^ t_word;
        end
        last_word = (widx_reg == WW'(7'({1'b0, nk_reg, 2'b00}) + 7'd27));
    end

    // Round unit: one full encryption or decryption round per cycle, unless the last round waits on a stalled result.
    always_comb
    begin
        logic [7:0]      subs [16];
        aes_pkg::block_t x;
        aes_pkg::block_t z;
        aes_pkg::block_t mixed;
        for (int i = 0; i < 16; i++)
        begin
            subs[i] = dec_reg ? aes_pkg::INV_SBOX[blk_reg[127 - 8 * i -: 8]]
                              : aes_pkg::SBOX[blk_reg[127 - 8 * i -: 8]];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                x[127 - 8 * (4 * c + r) -: 8] = dec_reg ? subs[4 * ((c - r) & 3) + r]
                                                        : subs[4 * ((c + r) & 3) + r];
            end
        end
        z = x ^ ram_rdata;
        for (int c = 0; c < 4; c++)
        begin
            mixed[127 - 32 * c -: 32] = dec_reg ? aes_pkg::inv_mix_col(z[127 - 32 * c -: 32])
                                                : aes_pkg::mix_col(x[127 - 32 * c -: 32]);
        end
        if (dec_reg)
        begin
            round_out = last_round ? z : mixed;
        end
        else
        begin
            round_out = (last_round ? x : mixed) ^ ram_rdata;
        end
    end

    assign last_round = (rnd_reg == nr_reg);
    assign advance    = !(last_round && out_valid_reg && out_stall);

    // Round-key RAM addressing.
    always_comb
    begin
        ram_we     = (fsm_reg == S_EXPAND) && (widx_reg[1:0] == 2'b11);
        ram_waddr  = RW'(widx_reg >> 2);
        ram_re     = 1'b0;
        fetch_step = 4'd0;
        case (fsm_reg)
            S_FETCH:
            begin
                ram_re = 1'b1;
            end
            S_INIT:
            begin
                ram_re     = 1'b1;
                fetch_step = 4'd1;
            end
            S_ROUND:
            begin
                ram_re     = advance && !last_round;
                fetch_step = rnd_reg + 4'd1;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
        fetch_key = dec_reg ? (nr_reg - fetch_step) : fetch_step;
        ram_raddr = RW'(fetch_key);
    end

    aes_ram #(
        .WIDTH (128),
        .DEPTH (ROWS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({rowbuf_reg, new_word}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer.
    always_comb
    begin
        fsm_next        = fsm_reg;
        keys_ready_next = keys_ready_reg;
        nk_next         = nk_reg;
        nr_next         = nr_reg;
        rnd_next        = rnd_reg;
        widx_next       = widx_reg;
        kpos_next       = kpos_reg;
        rcon_next       = rcon_reg;
        blk_next        = blk_reg;
        out_valid_next  = out_valid_reg && out_stall;
        case (fsm_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    blk_next  = {block_upper, block_lower};
                    widx_next = '0;
                    kpos_next = 3'd0;
                    rcon_next = aes_pkg::RCON_FIRST;
                    if (keys_ready_reg)
                    begin
                        fsm_next = S_FETCH;
                    end
                    else
                    begin
                        nk_next  = nk_req;
                        nr_next  = nk_req + 4'd6;
                        fsm_next = S_EXPAND;
                    end
                end
            end
            S_EXPAND:
            begin
                widx_next = widx_reg + WW'(1);
                kpos_next = (kpos_reg == 3'(nk_reg - 4'd1)) ? 3'd0 : kpos_reg + 3'd1;
                if (is_rot)
                begin
                    rcon_next = aes_pkg::xtime(rcon_reg);
                end
                if (last_word)
                begin
                    keys_ready_next = 1'b1;
                    fsm_next        = S_FETCH;
                end
            end
            S_FETCH:
            begin
                fsm_next = S_INIT;
            end
            S_INIT:
            begin
                blk_next = blk_reg ^ ram_rdata;
                rnd_next = 4'd1;
                fsm_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (advance)
                begin
                    blk_next = round_out;
                    rnd_next = rnd_reg + 4'd1;
                    if (last_round)
                    begin
                        out_valid_next = 1'b1;
                        fsm_next       = S_IDLE;
                    end
                end
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
        if (cfg_take && (cfg_index == aes_pkg::CFG_KEY_LENGTH || cfg_index == aes_pkg::CFG_KEY_0
            || cfg_index == aes_pkg::CFG_KEY_1 || cfg_index == aes_pkg::CFG_KEY_2
            || cfg_index == aes_pkg::CFG_KEY_3))
        begin
            keys_ready_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= S_IDLE;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            nk_reg         <= 4'd4;
            nr_reg         <= 4'd10;
            rnd_reg        <= 4'd0;
            widx_reg       <= '0;
            kpos_reg       <= 3'd0;
            rcon_reg       <= aes_pkg::RCON_FIRST;
            key_len_reg    <= 2'd0;
            dec_reg        <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= 64'd0;
            end
        end
        else
        begin
            fsm_reg        <= fsm_next;
            keys_ready_reg <= keys_ready_next;
            out_valid_reg  <= out_valid_next;
            nk_reg         <= nk_next;
            nr_reg         <= nr_next;
            rnd_reg        <= rnd_next;
            widx_reg       <= widx_next;
            kpos_reg       <= kpos_next;
            rcon_reg       <= rcon_next;
            if (cfg_take)
            begin
                case (cfg_index)
                    aes_pkg::CFG_KEY_LENGTH: key_len_reg <= cfg_data[1:0];
                    aes_pkg::CFG_DECRYPT:    dec_reg     <= cfg_data[0];
                    aes_pkg::CFG_KEY_0:      key_reg[0]  <= cfg_data;
                    aes_pkg::CFG_KEY_1:      key_reg[1]  <= cfg_data;
                    aes_pkg::CFG_KEY_2:      key_reg[2]  <= cfg_data;
                    aes_pkg::CFG_KEY_3:      key_reg[3]  <= cfg_data;
                    default:                 key_len_reg <= key_len_reg;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (fsm_reg == S_EXPAND)
        begin
            rowbuf_reg <= {rowbuf_reg[63:0], new_word};
            for (int i = 0; i < 7; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[7] <= new_word;
        end
        if (fsm_reg == S_ROUND && advance && last_round)
        begin
            result_reg <= round_out;
        end
    end

    // Rounds run only on an expanded schedule.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_INIT || fsm_reg == S_ROUND) |-> keys_ready_reg)
        else $error("round started without an expanded key schedule");

    // The round counter never passes the round count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_ROUND) |-> (rnd_reg >= 4'd1 && rnd_reg <= nr_reg))
        else $error("round counter out of range");

    // Round-key RAM is written only during expansion.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (fsm_reg == S_EXPAND && !ram_re))
        else $error("round-key write outside key expansion");

    // A new result comes only out of the last round.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fsm_reg == S_ROUND && rnd_reg == nr_reg))
        else $error("result produced outside the last round");

endmodule

// File: dv/aes_block_cipher_checker.sv
// Checker for the AES block cipher: predicts every result and compares it on the output channel.
`timescale 1ns / 100ps

module aes_block_cipher_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] block_upper,
    input  logic [63:0] block_lower,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] result_upper,
    input  logic [63:0] result_lower,
    output int          fail_count,
    output int          pending_blocks
);

    // Shadow copy of the configuration registers.
    logic [1:0]  key_size_code;
    logic        decrypting;
    logic [63:0] key_reg [4];

    logic [7:0]  fwd_sub [256];
    logic [7:0]  inv_sub [256];
    logic [31:0] sched [60];
    int          num_rounds;

    aes_pkg::block_t expected_blocks [$];

    function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc ^= a;
            end
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    // The substitution box is built from the field inverse and the affine map.
    initial
    begin
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
            begin
                if (x != 0 && gf_mult(8'(x), 8'(y)) == 8'h01)
                begin
                    inv = 8'(y);
                end
            end
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[x] = s;
            inv_sub[s] = 8'(x);
        end
    end

    // Key schedule from the current key registers; a reserved size code means 256 bits.
    function automatic void build_schedule();
        int          nk;
        logic [31:0] t;
        logic [31:0] rc;
        nk = (key_size_code == 2'd0) ? 4 : (key_size_code == 2'd1) ? 6 : 8;
        for (int i = 0; i < nk; i++)
        begin
            sched[i] = (i % 2 == 1) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
        end
        for (int i = nk; i < 4 * nk + 28; i++)
        begin
            t = sched[i - 1];
            if (i % nk == 0)
            begin
                rc = 32'h01000000;
                for (int j = 1; j < i / nk; j++)
                begin
                    rc = {gf_mult(rc[31:24], 8'h02), 24'h0};
                end
                t = subst_word({t[23:0], t[31:24]}) ^ rc;
            end
            else if (nk > 6 && i % nk == 4)
            begin
                t = subst_word(t);
            end
            sched[i] = sched[i - nk] ^ t;
        end
        num_rounds = nk + 6;
    endfunction

    function automatic aes_pkg::block_t aes_transform(input aes_pkg::block_t blk);
        logic [7:0]      s [16];
        logic [7:0]      t [16];
        logic [7:0]      m [4];
        aes_pkg::block_t res;
        int              rnd;
        int              other;
        for (int i = 0; i < 16; i++)
        begin
            s[i] = blk[127 - 8 * i -: 8];
        end
        for (int step = 0; step <= num_rounds; step++)
        begin
            rnd = decrypting ? num_rounds - step : step;
            // Byte substitution and row shift, skipped on the initial key addition.
            if (step > 0)
            begin
                t = s;
                for (int c = 0; c < 4; c++)
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        other = 4 * ((c + r) % 4) + r;
                        if (decrypting)
                        begin
                            s[other] = inv_sub[t[4 * c + r]];
                        end
                        else
                        begin
                            s[4 * c + r] = fwd_sub[t[other]];
                        end
                    end
                end
            end
            // Forward mixing comes before the round key.
            if (!decrypting && step > 0 && step < num_rounds)
            begin
                m = '{8'h02, 8'h03, 8'h01, 8'h01};
                t = s;
                for (int c = 0; c < 4; c++)
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        s[4 * c + r] = gf_mult(t[4 * c], m[(4 - r) % 4])
                            ^ gf_mult(t[4 * c + 1], m[(5 - r) % 4])
                            ^ gf_mult(t[4 * c + 2], m[(6 - r) % 4])
                            ^ gf_mult(t[4 * c + 3], m[(7 - r) % 4]);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 4; r++)
                begin
                    s[4 * c + r] ^= sched[4 * rnd + c][31 - 8 * r -: 8];
                end
            end
            // Inverse mixing follows the round key.
            if (decrypting && step > 0 && step < num_rounds)
            begin
                m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
                t = s;
                for (int c = 0; c < 4; c++)
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        s[4 * c + r] = gf_mult(t[4 * c], m[(4 - r) % 4])
                            ^ gf_mult(t[4 * c + 1], m[(5 - r) % 4])
                            ^ gf_mult(t[4 * c + 2], m[(6 - r) % 4])
                            ^ gf_mult(t[4 * c + 3], m[(7 - r) % 4]);
                    end
                end
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            res[127 - 8 * i -: 8] = s[i];
        end
        return res;
    endfunction

    // Track configuration, queue predictions and compare results.
    always @(posedge clk or negedge rst_n)
    begin
        aes_pkg::block_t exp_blk;
        if (!rst_n)
        begin
            key_size_code = 2'd0;
            decrypting = 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] = 64'h0;
            end
            expected_blocks.delete();
            fail_count = 0;
            pending_blocks = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $error("result with no block outstanding: %h %h", result_upper,
                           result_lower);
                    fail_count++;
                end
                else
                begin
                    exp_blk = expected_blocks.pop_front();
                    if (result_upper !== exp_blk[127:64])
                    begin
                        $error("result_upper expected %h actual %h", exp_blk[127:64],
                               result_upper);
                        fail_count++;
                    end
                    if (result_lower !== exp_blk[63:0])
                    begin
                        $error("result_lower expected %h actual %h", exp_blk[63:0],
                               result_lower);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                build_schedule();
                expected_blocks.push_back(aes_transform({block_upper, block_lower}));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    aes_pkg::CFG_KEY_LENGTH: key_size_code = cfg_data[1:0];
                    aes_pkg::CFG_DECRYPT:    decrypting = cfg_data[0];
                    aes_pkg::CFG_KEY_0:      key_reg[0] = cfg_data;
                    aes_pkg::CFG_KEY_1:      key_reg[1] = cfg_data;
                    aes_pkg::CFG_KEY_2:      key_reg[2] = cfg_data;
                    aes_pkg::CFG_KEY_3:      key_reg[3] = cfg_data;
                    default:                 ;
                endcase
            end
            pending_blocks = expected_blocks.size();
        end
    end

endmodule

// File: dv/aes_block_cipher_tb.sv
// Testbench top for the AES block cipher: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module aes_block_cipher_tb;

    localparam logic [1:0] KEY_256  = 2'd2;
    localparam logic [1:0] KEY_RSVD = 2'd3;
    localparam logic [2:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [2:0] CFG_UNUSED_7 = 3'd7;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] block_upper = '0;
    logic [63:0] block_lower = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] result_upper;
    logic [63:0] result_lower;

    int fail_count;
    int pending_blocks;
    int quiet_cycles = 0;
    bit hold_request = 1'b0;
    bit no_idling = 1'b0;

    always #5 clk = ~clk;

    aes_block_cipher u_top (.*);

    aes_block_cipher_checker u_checker (.*);

    // Random 64-bit value, sometimes an extreme.
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Watchdog on cycles with no transfer on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Output side: random stall bursts, one long hold-off on request, none at the end.
    initial
    begin
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (no_idling)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= $urandom_range(0, 2) == 0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    end

    // Wait for every outstanding result, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_blocks != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_key(input logic [1:0] size, input logic dec,
                            input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        write_reg(aes_pkg::CFG_KEY_LENGTH,
                  {$urandom, 30'($urandom_range(0, 32'h3fffffff)), size});
        write_reg(aes_pkg::CFG_DECRYPT,
                  {$urandom, 31'($urandom_range(0, 32'h7fffffff)), dec});
        write_reg(aes_pkg::CFG_KEY_0, k0);
        write_reg(aes_pkg::CFG_KEY_1, k1);
        write_reg(aes_pkg::CFG_KEY_2, k2);
        write_reg(aes_pkg::CFG_KEY_3, k3);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Leaves in_valid high so back-to-back items need no extra assignment.
    task automatic send_block(input logic [63:0] up, input logic [63:0] lo);
        in_valid <= 1'b1;
        block_upper <= up;
        block_lower <= lo;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_items(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_block(rand_word(), rand_word());
            if (!no_idling && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        logic [1:0] size;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Standard test key and plaintext for 128 bits; unlisted indexes are ignored.
        write_reg(CFG_UNUSED_6, '1);
        write_reg(CFG_UNUSED_7, '1);
        load_key(aes_pkg::KEY_128, 1'b0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        drain();

        load_key(aes_pkg::KEY_192, 1'b0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(64'h0, 64'h0);
        drain();

        load_key(KEY_256, 1'b0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();

        // Decryption of the 256-bit test ciphertext, then a mode switch with the key kept.
        write_reg(aes_pkg::CFG_DECRYPT, 64'h1);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_block(64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        send_block('1, '1);
        drain();
        write_reg(aes_pkg::CFG_DECRYPT, 64'h0);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();

        // Reserved size code and extreme keys.
        load_key(KEY_RSVD, 1'b1, '1, '1, '1, '1);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        drain();
        load_key(aes_pkg::KEY_128, 1'b1, 64'h0, 64'h0, 64'h0, 64'h0);
        send_block(64'h0, 64'h0);
        send_block('1, 64'h0);
        drain();
        load_key(aes_pkg::KEY_192, 1'b1, '1, 64'h0, '1, 64'h0);
        send_block(64'h0, '1);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        drain();

        // Random phases over all key sizes and both directions.
        for (int ph = 0; ph < 12; ph++)
        begin
            size = 2'($urandom_range(0, 3));
            if (ph == 0 || $urandom_range(0, 2) != 0)
            begin
                load_key(size, 1'($urandom), rand_word(), rand_word(), rand_word(),
                         rand_word());
            end
            else
            begin
                write_reg(aes_pkg::CFG_DECRYPT, {$urandom, $urandom});
                cfg_valid <= 1'b0;
                @(posedge clk);
            end
            if (ph == 4)
            begin
                hold_request = 1'b1;
            end
            if (ph == 11)
            begin
                no_idling = 1'b1;
            end
            random_items(50);
            drain();
        end

        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
